>>> design/fpt_pkg.sv
// Package for the fractional period timer: sizes, codes, payload types and the
// command and status bundles between controller and datapath.
// No dependencies.
package fpt_pkg;

    // Counter clock rate and the number of period units per second.
    localparam int CLOCK_HZ         = 32768;
    localparam int UNITS_PER_SECOND = 10000;

    // The period is scaled to clocks by a fixed-point reciprocal: the clock count
    // is (period * SCALE_MUL) >> SCALE_SHIFT, which is exact for every 16-bit period.
    localparam int     SCALE_SHIFT = 30;
    localparam longint SCALE_MUL   = ((64'd1 << SCALE_SHIFT) * CLOCK_HZ
                                      + UNITS_PER_SECOND - 1) / UNITS_PER_SECOND;

    // Largest clock count, and the widths that follow from it.
    localparam longint MAX_CLOCKS = 64'd65535 * CLOCK_HZ / UNITS_PER_SECOND;
    localparam int QUOT_W = $clog2(MAX_CLOCKS + 1);
    localparam int PROD_W = SCALE_SHIFT + QUOT_W;
    localparam int STEP_W = $clog2(QUOT_W + 1);

    localparam logic [15:0] RELOAD_RESET = 16'd32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD = 1'b1;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_STOP   = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_SAMPLE = 2'd3
    } fpt_req_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] counter_value;
    } fpt_in_t;

    typedef struct packed {
        logic        fire;
        logic        compare_armed;
        logic [15:0] compare_point;
        logic [15:0] ticks_left;
    } fpt_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec_simple;
        logic div_load;
        logic start_commit;
        logic out_load;
    } fpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic out_free;
    } fpt_sts_t;

endpackage

>>> design/fpt_div.sv
// Restoring divider, one quotient bit per cycle, for the fractional period timer.
// Depends on fpt_pkg.
module fpt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [15:0]                 init_rem,
    input  logic [fpt_pkg::QUOT_W-1:0]  init_dvd,
    input  logic [15:0]                 divisor,
    output logic                        done,
    output logic [fpt_pkg::QUOT_W-1:0]  quotient,
    output logic [15:0]                 remainder
);
    import fpt_pkg::*;

    logic [15:0]        rem_reg, rem_next;
    logic [QUOT_W-1:0]  dvd_reg, dvd_next;
    logic [15:0]        div_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic [16:0]        shifted;
    logic [17:0]        diff;
    logic               ge;

    // Shift in the next dividend bit and try a subtraction.
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[QUOT_W-1]};
        diff     = {1'b0, shifted} - {2'b00, div_reg};
        ge       = ~diff[17];
        rem_next = ge ? diff[15:0] : shifted[15:0];
        dvd_next = {dvd_reg[QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= STEP_W'(QUOT_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= init_rem;
            dvd_reg <= init_dvd;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done      = (cnt_reg == '0);
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

    // The partial remainder stays below the divisor while a division runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 |-> rem_reg < div_reg)
        else $error("fpt_div: partial remainder not below divisor");

    // A load starts a full pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> cnt_reg == STEP_W'(QUOT_W))
        else $error("fpt_div: load did not start a full pass");

    // The step counter never exceeds the quotient width.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= STEP_W'(QUOT_W))
        else $error("fpt_div: step counter out of range");

endmodule

>>> design/fpt_dp.sv
// Datapath of the fractional period timer: configuration, timer state, the
// period scaling, the divider and the result register. Depends on fpt_pkg and fpt_div.
module fpt_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                      cfg_wdata,
    input  fpt_pkg::fpt_in_t                 in_data,
    input  fpt_pkg::fpt_cmd_t                cmd,
    input  logic                             out_ready,
    output fpt_pkg::fpt_sts_t                sts,
    output logic                             out_valid,
    output fpt_pkg::fpt_out_t                out_data
);
    import fpt_pkg::*;

    logic [15:0] period_reg, reload_reg;
    logic [15:0] whole_reg, remclk_reg, countdown_reg, phase_reg, compare_reg;
    logic        armed_reg, fire_reg;
    logic        out_valid_reg;
    fpt_out_t    out_reg;

    logic [15:0]        eff_rl;
    logic [PROD_W-1:0]  product;
    logic [QUOT_W-1:0]  clocks, div_quot;
    logic               div_done;
    logic [15:0]        div_rem;
    logic [15:0]        whole_sat;

    logic [16:0] sum17;
    logic        wrap, match;
    logic [15:0] phase_new, cnt_new;

    assign eff_rl  = (reload_reg == '0) ? 16'd1 : reload_reg;

    // The period becomes a clock count by a reciprocal multiply; the divider
    // then splits that count into whole ticks and leftover clocks.
    assign product = PROD_W'(period_reg) * PROD_W'(SCALE_MUL);
    assign clocks  = product[PROD_W-1:SCALE_SHIFT];

    fpt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.div_load),
        .init_rem  (16'd0),
        .init_dvd  (clocks),
        .divisor   (eff_rl),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign whole_sat = (32'(div_quot) > 32'hFFFF) ? 16'hFFFF : 16'(div_quot);

    // Compare match: advance the phase by the remainder and carry a tick on wrap.
    always_comb
    begin
        sum17     = {1'b0, compare_reg} + {1'b0, remclk_reg};
        wrap      = (sum17 >= {1'b0, eff_rl});
        phase_new = wrap ? 16'(sum17 - {1'b0, eff_rl}) : sum17[15:0];
        if (wrap && whole_reg != 16'hFFFF)
        begin
            cnt_new = whole_reg + 16'd1;
        end
        else
        begin
            cnt_new = whole_reg;
        end
        match = armed_reg && (in_data.counter_value == compare_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            reload_reg <= RELOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD: period_reg <= cfg_wdata;
                CFG_RELOAD: reload_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg     <= '0;
            remclk_reg    <= '0;
            countdown_reg <= '0;
            phase_reg     <= '0;
            compare_reg   <= '0;
            armed_reg     <= 1'b0;
            fire_reg      <= 1'b0;
        end
        else if (cmd.start_commit)
        begin
            whole_reg     <= whole_sat;
            remclk_reg    <= div_rem;
            countdown_reg <= '0;
            compare_reg   <= {1'b0, reload_reg[15:1]};
            armed_reg     <= 1'b1;
            fire_reg      <= 1'b0;
        end
        else if (cmd.exec_simple)
        begin
            fire_reg <= 1'b0;
            unique case (in_data.req_type)
                REQ_STOP:
                begin
                    armed_reg     <= 1'b0;
                    countdown_reg <= '0;
                end
                REQ_TICK:
                begin
                    if (countdown_reg != '0)
                    begin
                        countdown_reg <= countdown_reg - 16'd1;
                        if (countdown_reg == 16'd1)
                        begin
                            compare_reg <= phase_reg;
                            armed_reg   <= 1'b1;
                        end
                    end
                end
                REQ_SAMPLE:
                begin
                    if (match)
                    begin
                        countdown_reg <= cnt_new;
                        phase_reg     <= phase_new;
                        armed_reg     <= 1'b0;
                        fire_reg      <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.fire          <= fire_reg;
            out_reg.compare_armed <= armed_reg;
            out_reg.compare_point <= compare_reg;
            out_reg.ticks_left    <= countdown_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = ~out_valid_reg | out_ready;

    // A fired event always leaves the compare disarmed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.fire |-> !out_reg.compare_armed)
        else $error("fpt_dp: event reported with compare still armed");

    // A start leaves the compare armed with the countdown cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_commit |=> armed_reg && countdown_reg == '0 && !fire_reg)
        else $error("fpt_dp: start did not arm the compare");

    // A waiting result stays valid and unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_reg))
        else $error("fpt_dp: waiting result changed or dropped");

endmodule

>>> design/fpt_ctrl.sv
// Controller of the fractional period timer: sequences the single step of a stop,
// tick or sample item, the divider pass of a start and the loading of the result register. Depends on fpt_pkg.
module fpt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         req_type,
    input  fpt_pkg::fpt_sts_t  sts,
    output logic               in_ready,
    output fpt_pkg::fpt_cmd_t  cmd
);
    import fpt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_START)
                    begin
                        cmd.div_load = 1'b1;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        cmd.exec_simple = 1'b1;
                        state_next      = ST_RESULT;
                    end
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.start_commit = 1'b1;
                    state_next       = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The result register is only loaded when its previous item has gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("fpt_ctrl: result register overwritten");

    // No new item is taken while the divider is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> sts.div_done)
        else $error("fpt_ctrl: ready while divider busy");

    // At most one datapath command per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec_simple, cmd.div_load, cmd.start_commit, cmd.out_load}))
        else $error("fpt_ctrl: conflicting datapath commands");

endmodule

>>> design/fractional_period_timer.sv
// Fractional period timer. A stop, tick or sample item is executed when it is taken,
// and its result is loaded into the output register once the output is free; a
// new item is accepted after that load.
// A start item scales the period by a reciprocal multiply and runs one pass of a
// bit-serial divider by the tick reload over the QUOT_W (18) quotient bits; the start
// is then committed, its result is loaded once the output is free, and the next item is accepted after that load.
// Reset (asynchronous, active low) clears all timer state and returns the
// configuration registers to their reset values.
module fractional_period_timer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  fpt_pkg::fpt_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fpt_pkg::fpt_out_t              out_data
);
    import fpt_pkg::*;

    // The controller and datapath talk only through these two bundles.
    fpt_cmd_t cmd;
    fpt_sts_t sts;

    // The controller sequences each item: one step for stop, tick and sample,
    // one divider pass and a commit for a start, then a load of the result register.
    fpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the timer state, the divider and
    // the output register, which lets a new item in while a result waits.
    fpt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_ready (out_ready),
        .sts       (sts),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
